/* hw/rtl/bbpe_pkg.sv */
// ----------------------------------------------------------------------------
// bbpe_pkg
// Shared types and constants of the bicubic Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbpe_pkg;

  // coordinate and parameter formats
  localparam int unsigned COORD_W = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PARAM_W = FRAC_W + 1;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned NPTS    = 16;

  // rebuilt interior points need two more bits than a stored point
  localparam int unsigned KEXT_W = COORD_W + 2;
  // weight times point
  localparam int unsigned PROD_W = PARAM_W + 1 + KEXT_W;
  // sixteen terms with weights summing to about one
  localparam int unsigned ACC_W  = PROD_W + 4;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // one queued item
  typedef struct packed {
    logic                       cmd;
    logic [IDX_W-1:0]           index;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [PARAM_W-1:0]         s;
    logic [PARAM_W-1:0]         t;
  } item_t;

  // handshake of the queue write side
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // interior points are rebuilt, never loaded
  function automatic logic is_interior(input logic [IDX_W-1:0] idx);
    is_interior = (idx == IDX_W'(5)) || (idx == IDX_W'(6)) ||
                  (idx == IDX_W'(9)) || (idx == IDX_W'(10));
  endfunction

endpackage

/* hw/rtl/bicubic_bezier_patch_eval.sv */
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval
// Evaluates a 2D bicubic Bezier patch whose interior points are rebuilt
// from the boundary by the parallelogram rule.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries load and evaluate items; the output channel
//   carries one surface point per evaluate item, none per load.
//   A load writes a boundary point; loads to interior indices are taken
//   and discarded. An evaluate item passes through the queue, then takes
//   14 steps on the shared weight multiplier for the Bernstein weights of
//   s and t, runs its 16 terms through the weight-point-accumulate
//   pipeline and its drain, then passes the magnitude-and-sign and the
//   round-and-saturate states. The back takes no new item until the
//   result of the current evaluate is written to the output register.
//   A two-entry queue sits between the front and the back, so up to two
//   items are taken while the back is busy. The next item is taken while a
//   finished result waits in the output register; a stalled receiver holds
//   the back only once the next result is ready to be written.
//   Reset clears all control points to zero and empties the queue and the
//   output register.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [bbpe_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [bbpe_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bbpe_pkg::COORD_W-1:0] point_y_i,
  input  logic [bbpe_pkg::PARAM_W-1:0]        param_s_i,
  input  logic [bbpe_pkg::PARAM_W-1:0]        param_t_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bbpe_pkg::COORD_W-1:0] surface_x_o,
  output logic signed [bbpe_pkg::COORD_W-1:0] surface_y_o
);

  bbpe_pkg::push_t push;
  logic            push_ready;
  logic            pop_valid;
  logic            pop_ready;
  bbpe_pkg::item_t pop_item;

  // classify and clamp
  bbpe_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .param_s_i     (param_s_i),
    .param_t_i     (param_t_i),
    .push_o        (push),
    .push_ready_i  (push_ready)
  );

  // decoupling queue
  bbpe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // point store and evaluation
  bbpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .surface_x_o (surface_x_o),
    .surface_y_o (surface_y_o)
  );

endmodule

/* hw/rtl/bbpe_front.sv */
// ----------------------------------------------------------------------------
// bbpe_front
// Accepts items, drops interior loads and clamps parameters to one.
// ----------------------------------------------------------------------------
module bbpe_front (
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [bbpe_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [bbpe_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bbpe_pkg::COORD_W-1:0] point_y_i,
  input  logic [bbpe_pkg::PARAM_W-1:0]        param_s_i,
  input  logic [bbpe_pkg::PARAM_W-1:0]        param_t_i,
  output bbpe_pkg::push_t                     push_o,
  input  logic                                push_ready_i
);

  logic drop;

  // interior loads are taken and discarded
  assign drop = (command_i == bbpe_pkg::CMD_LOAD) && bbpe_pkg::is_interior(point_index_i);

  assign in_ready_o = drop | push_ready_i;

  // build the queue entry
  always_comb begin
    push_o.valid      = in_valid_i & ~drop;
    push_o.item.cmd   = command_i;
    push_o.item.index = point_index_i;
    push_o.item.x     = point_x_i;
    push_o.item.y     = point_y_i;
    push_o.item.s     = (param_s_i > bbpe_pkg::PARAM_ONE) ? bbpe_pkg::PARAM_ONE : param_s_i;
    push_o.item.t     = (param_t_i > bbpe_pkg::PARAM_ONE) ? bbpe_pkg::PARAM_ONE : param_t_i;
  end

endmodule

/* hw/rtl/bbpe_fifo.sv */
// ----------------------------------------------------------------------------
// bbpe_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module bbpe_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbpe_pkg::push_t   push_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output bbpe_pkg::item_t   pop_item_o,
  input  logic              pop_ready_i
);

  bbpe_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign wr_en = push_i.valid & push_ready_o;
  assign rd_en = pop_valid_o & pop_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

/* hw/rtl/bbpe_back.sv */
// ----------------------------------------------------------------------------
// bbpe_back
// Holds the control points, computes Bernstein weights on a shared
// multiplier and accumulates the sixteen weighted points.
// ----------------------------------------------------------------------------
module bbpe_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  input  bbpe_pkg::item_t                     pop_item_i,
  output logic                                pop_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bbpe_pkg::COORD_W-1:0] surface_x_o,
  output logic signed [bbpe_pkg::COORD_W-1:0] surface_y_o
);

  localparam int unsigned CW = bbpe_pkg::COORD_W;
  localparam int unsigned PW = bbpe_pkg::PARAM_W;
  localparam int unsigned FW = bbpe_pkg::FRAC_W;
  localparam int unsigned KW = bbpe_pkg::KEXT_W;
  localparam int unsigned XW = bbpe_pkg::PROD_W;
  localparam int unsigned AW = bbpe_pkg::ACC_W;
  localparam int unsigned MW = 2 * PW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WGT  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [2:0] STEP_LAST = 3'd6;

  // control points
  logic signed [CW-1:0] pts_x_q [bbpe_pkg::NPTS];
  logic signed [CW-1:0] pts_y_q [bbpe_pkg::NPTS];

  logic [2:0]    state_q, state_d;
  logic          half_q;
  logic [2:0]    step_q;
  logic [4:0]    issue_q;
  logic          a_vld_q, b_vld_q;

  logic [PW-1:0] s_q, t_q;
  logic [PW-1:0] ss_q, uu_q, su_q;
  logic [PW-1:0] ws_q [4];
  logic [PW-1:0] wt_q [4];

  logic [PW-1:0] w_q;
  logic signed [KW-1:0] kx_q, ky_q;
  logic signed [XW-1:0] px_q, py_q;
  logic signed [AW-1:0] accx_q, accy_q;
  logic          negx_q, negy_q;
  logic [AW-1:0] magx_q, magy_q;

  logic          out_valid_q;
  logic signed [CW-1:0] surf_x_q, surf_y_q;

  logic [PW-1:0] p_sel, u_sel, su3;
  logic [PW-1:0] mul_a, mul_b;
  logic [MW-1:0] mul_prod;
  logic [MW:0]   mul_sum;
  logic [PW-1:0] mul_rnd;
  logic signed [KW-1:0] kx_sel, ky_sel;
  logic [1:0]    wi;
  logic          issuing;
  logic          out_free;

  // sign-extend a stored coordinate
  function automatic logic signed [KW-1:0] ext(input logic signed [CW-1:0] v);
    ext = KW'(v);
  endfunction

  // round, saturate and restore the sign of a magnitude
  function automatic logic signed [CW-1:0] finish(input logic [AW-1:0] mag,
                                                  input logic neg);
    logic [AW-1:0] sum;
    logic [AW-FW-1:0] q;
    logic [AW-FW-1:0] lim;
    sum = mag + AW'(1 << (FW - 1));
    q   = sum[AW-1:FW];
    lim = (AW-FW)'(1) << (CW - 1);
    if (neg) begin
      finish = (q > lim) ? {1'b1, {(CW-1){1'b0}}} : -$signed(q[CW-1:0]);
    end else begin
      finish = (q >= lim) ? {1'b0, {(CW-1){1'b1}}} : $signed(q[CW-1:0]);
    end
  endfunction

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_free    = ~out_valid_q | out_ready_i;
  assign issuing     = (state_q == ST_MAC) && !issue_q[4];
  assign wi          = 2'(step_q - 3'd3);

  // weight unit operand selection
  always_comb begin
    p_sel = half_q ? t_q : s_q;
    u_sel = bbpe_pkg::PARAM_ONE - p_sel;
    su3   = (su_q << 1) + su_q;
    mul_a = ws_q[issue_q[1:0]];
    mul_b = wt_q[issue_q[3:2]];
    if (state_q == ST_WGT) begin
      case (step_q)
        3'd0:    begin mul_a = p_sel; mul_b = p_sel; end
        3'd1:    begin mul_a = u_sel; mul_b = u_sel; end
        3'd2:    begin mul_a = p_sel; mul_b = u_sel; end
        3'd3:    begin mul_a = uu_q;  mul_b = u_sel; end
        3'd4:    begin mul_a = su3;   mul_b = u_sel; end
        3'd5:    begin mul_a = su3;   mul_b = p_sel; end
        default: begin mul_a = ss_q;  mul_b = p_sel; end
      endcase
    end
  end

  // shared multiply with round to nearest
  assign mul_prod = mul_a * mul_b;
  assign mul_sum  = {1'b0, mul_prod} + (MW+1)'(1 << (FW - 1));
  assign mul_rnd  = mul_sum[FW +: PW];

  // point fetch with interior rebuild
  always_comb begin
    case (issue_q[3:0])
      4'd5: begin
        kx_sel = ext(pts_x_q[1]) + ext(pts_x_q[4]) - ext(pts_x_q[0]);
        ky_sel = ext(pts_y_q[1]) + ext(pts_y_q[4]) - ext(pts_y_q[0]);
      end
      4'd6: begin
        kx_sel = ext(pts_x_q[2]) + ext(pts_x_q[7]) - ext(pts_x_q[3]);
        ky_sel = ext(pts_y_q[2]) + ext(pts_y_q[7]) - ext(pts_y_q[3]);
      end
      4'd9: begin
        kx_sel = ext(pts_x_q[13]) + ext(pts_x_q[8]) - ext(pts_x_q[12]);
        ky_sel = ext(pts_y_q[13]) + ext(pts_y_q[8]) - ext(pts_y_q[12]);
      end
      4'd10: begin
        kx_sel = ext(pts_x_q[11]) + ext(pts_x_q[14]) - ext(pts_x_q[15]);
        ky_sel = ext(pts_y_q[11]) + ext(pts_y_q[14]) - ext(pts_y_q[15]);
      end
      default: begin
        kx_sel = ext(pts_x_q[issue_q[3:0]]);
        ky_sel = ext(pts_y_q[issue_q[3:0]]);
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && pop_item_i.cmd == bbpe_pkg::CMD_EVAL) begin
          state_d = ST_WGT;
        end
      end
      ST_WGT: begin
        if (half_q && step_q == STEP_LAST) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue_q[4] && !a_vld_q && !b_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and point store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= 1'b0;
      step_q      <= 3'd0;
      issue_q     <= 5'd0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bbpe_pkg::NPTS; i++) begin
        pts_x_q[i] <= '0;
        pts_y_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      a_vld_q <= issuing;
      b_vld_q <= a_vld_q;

      // load transfer writes a boundary point
      if (state_q == ST_IDLE && pop_valid_i && pop_item_i.cmd == bbpe_pkg::CMD_LOAD) begin
        pts_x_q[pop_item_i.index] <= pop_item_i.x;
        pts_y_q[pop_item_i.index] <= pop_item_i.y;
      end

      // weight step counters
      if (state_q == ST_IDLE) begin
        half_q <= 1'b0;
        step_q <= 3'd0;
      end else if (state_q == ST_WGT) begin
        if (step_q == STEP_LAST) begin
          step_q <= 3'd0;
          half_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end

      // term issue counter
      if (state_q != ST_MAC) begin
        issue_q <= 5'd0;
      end else if (issuing) begin
        issue_q <= issue_q + 5'd1;
      end

      // output register
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // capture parameters of each transfer; only an evaluate uses them
    if (state_q == ST_IDLE && pop_valid_i) begin
      s_q <= pop_item_i.s;
      t_q <= pop_item_i.t;
    end

    // weight results
    if (state_q == ST_WGT) begin
      case (step_q)
        3'd0: ss_q <= mul_rnd;
        3'd1: uu_q <= mul_rnd;
        3'd2: su_q <= mul_rnd;
        default: begin
          if (half_q) begin
            wt_q[wi] <= mul_rnd;
          end else begin
            ws_q[wi] <= mul_rnd;
          end
        end
      endcase
    end

    // term pipeline: weight and point, product, accumulate
    w_q  <= mul_rnd;
    kx_q <= kx_sel;
    ky_q <= ky_sel;
    px_q <= $signed({1'b0, w_q}) * kx_q;
    py_q <= $signed({1'b0, w_q}) * ky_q;
    if (state_q == ST_WGT) begin
      accx_q <= '0;
      accy_q <= '0;
    end else if (b_vld_q) begin
      accx_q <= accx_q + AW'(px_q);
      accy_q <= accy_q + AW'(py_q);
    end

    // magnitude and sign
    if (state_q == ST_FIN) begin
      negx_q <= accx_q[AW-1];
      negy_q <= accy_q[AW-1];
      magx_q <= accx_q[AW-1] ? AW'(-accx_q) : AW'(accx_q);
      magy_q <= accy_q[AW-1] ? AW'(-accy_q) : AW'(accy_q);
    end

    // rounded and saturated result
    if (state_q == ST_OUT && out_free) begin
      surf_x_q <= finish(magx_q, negx_q);
      surf_y_q <= finish(magy_q, negy_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign surface_x_o = surf_x_q;
  assign surface_y_o = surf_y_q;

endmodule

/* tb/tb_bicubic_bezier_patch_eval.sv */
// ----------------------------------------------------------------------------
// tb_bicubic_bezier_patch_eval
// Self-checking bench for the bicubic Bezier patch evaluator. A queue of
// load and evaluate items feeds a valid/ready driver, and a fixed-point patch
// predictor with its own copy of the control points works out every surface
// point. A monitor compares each output transfer with the oldest prediction.
// Random stalls are applied on both channels in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_bicubic_bezier_patch_eval;
  timeunit 1ns;
  timeprecision 1ps;

  import bbpe_pkg::*;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [PARAM_W-1:0]        PARAM_TOP = '1;
  localparam int unsigned RANDOM_ITEMS   = 425;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } surface_pt_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_ready;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [COORD_W-1:0]  surface_x;
  logic signed [COORD_W-1:0]  surface_y;
  item_t                      drv_item;

  item_t       item_q[$];
  surface_pt_t surface_q[$];
  longint      patch_x[NPTS];
  longint      patch_y[NPTS];
  logic        in_taken;
  int unsigned sent_cnt;
  int unsigned total_items;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned idle_cycles;
  int unsigned mismatch_cnt;

  bicubic_bezier_patch_eval dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (drv_item.cmd),
    .point_index_i (drv_item.index),
    .point_x_i     (drv_item.x),
    .point_y_i     (drv_item.y),
    .param_s_i     (drv_item.s),
    .param_t_i     (drv_item.t),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .surface_x_o   (surface_x),
    .surface_y_o   (surface_y)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // patch predictor
  // ---------------------------------------------------------------------------

  // round a non-negative value to nearest at the fraction point
  function automatic longint unsigned rnd_frac(input longint unsigned v);
    return (v + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
  endfunction

  // cubic Bernstein weights of one parameter, clamped to one
  function automatic void bern_weights(input logic [PARAM_W-1:0] p,
                                       output longint unsigned w[4]);
    longint unsigned s, u, ss, uu, su;
    s = p;
    if (s > PARAM_ONE) s = PARAM_ONE;
    u  = longint'(PARAM_ONE) - s;
    ss = rnd_frac(s * s);
    uu = rnd_frac(u * u);
    su = rnd_frac(s * u);
    w[0] = rnd_frac(uu * u);
    w[1] = rnd_frac(3 * su * u);
    w[2] = rnd_frac(3 * su * s);
    w[3] = rnd_frac(ss * s);
  endfunction

  // scale the sum back, round half away from zero, then saturate
  function automatic logic signed [COORD_W-1:0] round_sat(input longint acc);
    longint unsigned mag, q;
    longint          r;
    bit              neg;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    q   = rnd_frac(mag);
    if (q > (64'd1 << (COORD_W - 1))) q = 64'd1 << (COORD_W - 1);
    r = neg ? -longint'(q) : longint'(q);
    if (r > longint'(COORD_MAX)) r = COORD_MAX;
    if (r < longint'(COORD_MIN)) r = COORD_MIN;
    return r[COORD_W-1:0];
  endfunction

  // update the point store or predict one surface point
  task automatic patch_predict(input item_t it);
    longint          kx[NPTS];
    longint          ky[NPTS];
    longint unsigned ws[4];
    longint unsigned wt[4];
    longint          w, acc_x, acc_y;
    surface_pt_t     pt;
    if (it.cmd == CMD_LOAD) begin
      // interior points are never stored
      if (!(it.index inside {4'd5, 4'd6, 4'd9, 4'd10})) begin
        patch_x[it.index] = it.x;
        patch_y[it.index] = it.y;
      end
    end else begin
      kx = patch_x;
      ky = patch_y;
      // parallelogram rule for the interior
      kx[5]  = kx[1]  + kx[4]  - kx[0];
      ky[5]  = ky[1]  + ky[4]  - ky[0];
      kx[6]  = kx[2]  + kx[7]  - kx[3];
      ky[6]  = ky[2]  + ky[7]  - ky[3];
      kx[9]  = kx[13] + kx[8]  - kx[12];
      ky[9]  = ky[13] + ky[8]  - ky[12];
      kx[10] = kx[11] + kx[14] - kx[15];
      ky[10] = ky[11] + ky[14] - ky[15];
      bern_weights(it.s, ws);
      bern_weights(it.t, wt);
      acc_x = 0;
      acc_y = 0;
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          w = longint'(rnd_frac(ws[i] * wt[j]));
          acc_x += w * kx[i + 4 * j];
          acc_y += w * ky[i + 4 * j];
        end
      end
      pt.x = round_sat(acc_x);
      pt.y = round_sat(acc_y);
      surface_q.push_back(pt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return COORD_W'($urandom_range(255)) - COORD_W'(128);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PARAM_ONE;
      2:       return PARAM_W'($urandom_range(int'(PARAM_TOP), int'(PARAM_ONE) + 1));
      default: return PARAM_W'($urandom_range(int'(PARAM_ONE)));
    endcase
  endfunction

  function automatic item_t mk_load(input int idx, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
    item_t it;
    it.cmd   = CMD_LOAD;
    it.index = IDX_W'(idx);
    it.x     = x;
    it.y     = y;
    it.s     = PARAM_W'($urandom);
    it.t     = PARAM_W'($urandom);
    return it;
  endfunction

  function automatic item_t mk_eval(input logic [PARAM_W-1:0] s,
                                    input logic [PARAM_W-1:0] t);
    item_t it;
    it.cmd   = CMD_EVAL;
    it.index = IDX_W'($urandom);
    it.x     = rand_coord();
    it.y     = rand_coord();
    it.s     = s;
    it.t     = t;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // stall rates per phase
  // ---------------------------------------------------------------------------
  always_comb begin
    case ((total_items == 0) ? 2 : (sent_cnt * 3) / total_items)
      0:       begin send_idle = 11; recv_idle = 63; end
      1:       begin send_idle = 63; recv_idle = 11; end
      default: begin send_idle = 0;  recv_idle = 0;  end
    endcase
  end

  // driver: new item on the falling edge once the last one was transferred
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          drv_item <= item_q.pop_front();
          in_valid <= 1'b1;
          sent_cnt <= sent_cnt + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) patch_predict(drv_item);
      if (out_valid && out_ready) begin
        if (surface_q.size() == 0) begin
          $display("%0t: unexpected surface point x=%0d y=%0d", $time,
                   surface_x, surface_y);
          mismatch_cnt++;
        end else begin
          if (surface_x !== surface_q[0].x) begin
            $display("%0t: surface_x expected %0d, got %0d", $time,
                     surface_q[0].x, surface_x);
            mismatch_cnt++;
          end
          if (surface_y !== surface_q[0].y) begin
            $display("%0t: surface_y expected %0d, got %0d", $time,
                     surface_q[0].y, surface_y);
            mismatch_cnt++;
          end
          void'(surface_q.pop_front());
        end
      end
      // watchdog on cycles without any transfer
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    item_t       it;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    in_taken     = 1'b0;
    drv_item     = '0;
    sent_cnt     = 0;
    total_items  = 0;
    idle_cycles  = 0;
    mismatch_cnt = 0;
    foreach (patch_x[i]) begin
      patch_x[i] = 0;
      patch_y[i] = 0;
    end
    rst_ni = 1'b0;

    // directed: empty patch, extremes, interior loads, parameter corners
    item_q.push_back(mk_eval('0, '0));
    item_q.push_back(mk_load(0, COORD_MIN, COORD_MAX));
    item_q.push_back(mk_load(1, COORD_MAX, COORD_MIN));
    item_q.push_back(mk_load(4, COORD_MAX, COORD_MIN));
    item_q.push_back(mk_load(5, 24'd123, -24'sd456));
    item_q.push_back(mk_eval('0, '0));
    item_q.push_back(mk_eval(17'd21845, 17'd21845));
    item_q.push_back(mk_load(2, -24'sd1, 24'sd1));
    item_q.push_back(mk_load(3, '0, -24'sd1));
    item_q.push_back(mk_load(7, COORD_MIN, COORD_MIN));
    item_q.push_back(mk_load(8, COORD_MAX, COORD_MAX));
    item_q.push_back(mk_load(11, 24'sd1000, -24'sd1000));
    item_q.push_back(mk_load(12, COORD_MIN, COORD_MAX));
    item_q.push_back(mk_load(13, COORD_MAX, COORD_MIN));
    item_q.push_back(mk_load(14, -24'sd77, 24'sd9999));
    item_q.push_back(mk_load(15, COORD_MAX, COORD_MAX));
    item_q.push_back(mk_load(6, COORD_MAX, COORD_MAX));
    item_q.push_back(mk_load(9, COORD_MIN, COORD_MAX));
    item_q.push_back(mk_load(10, COORD_MAX, COORD_MIN));
    item_q.push_back(mk_eval(PARAM_ONE, PARAM_ONE));
    item_q.push_back(mk_eval(PARAM_TOP, PARAM_TOP));
    item_q.push_back(mk_eval(PARAM_ONE, '0));
    item_q.push_back(mk_eval(17'd32768, 17'd32768));
    item_q.push_back(mk_eval('0, 17'd100000));
    item_q.push_back(mk_eval(17'd1, 17'd65535));

    // random mix of loads and evaluations
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 55) begin
        it = mk_load($urandom_range(NPTS - 1), rand_coord(), rand_coord());
      end else begin
        it = mk_eval(rand_param(), rand_param());
      end
      counted++;
      item_q.push_back(it);
    end
    total_items = item_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all items, then all surface points, then let the block drain
    while (item_q.size() != 0 || in_valid) @(posedge clk_i);
    while (surface_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bbpe_pkg.sv
hw/rtl/bbpe_front.sv
hw/rtl/bbpe_fifo.sv
hw/rtl/bbpe_back.sv
hw/rtl/bicubic_bezier_patch_eval.sv
tb/tb_bicubic_bezier_patch_eval.sv
